FILE: rtl/lsrp_pkg.sv
package lsrp_pkg;

    // Layer store geometry
    localparam int MAX_LAYERS = 256;
    localparam int DIM_BITS   = 14;
    localparam int LAYER_BITS = $clog2(MAX_LAYERS);
    localparam int LCNT_BITS  = $clog2(MAX_LAYERS + 1);
    localparam int ENTRY_BITS = 3 * DIM_BITS;

    // Shared adder operand and sum widths
    localparam int OPA_BITS = DIM_BITS + 1;
    localparam int SUM_BITS = DIM_BITS + 2;

    // Result field widths
    localparam int POS_BITS    = 13;
    localparam int PLAYER_BITS = 8;
    localparam int STATUS_BITS = 2;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_LAYERS   = 2'd2;

    // Register reset values
    localparam logic [DIM_BITS-1:0]  ATLAS_WIDTH_RST  = DIM_BITS'(1024);
    localparam logic [DIM_BITS-1:0]  ATLAS_HEIGHT_RST = DIM_BITS'(512);
    localparam logic [LCNT_BITS-1:0] MAX_LAYERS_RST   = LCNT_BITS'(256);

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

    // Request to the shared add and compare unit
    typedef struct packed {
        logic [OPA_BITS-1:0] a;
        logic [DIM_BITS-1:0] b;
        logic [DIM_BITS-1:0] lim;
    } alu_req_t;

    // Answer from the shared add and compare unit
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                le;
    } alu_rsp_t;

endpackage

FILE: rtl/lsrp_ram.sv
module lsrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lsrp_alu.sv
module lsrp_alu (
    input  lsrp_pkg::alu_req_t req,
    output lsrp_pkg::alu_rsp_t rsp
);
    import lsrp_pkg::*;

    logic [SUM_BITS-1:0] sum;

    // Add the operands and check the sum against the limit
    always_comb begin
        sum     = SUM_BITS'(req.a) + SUM_BITS'(req.b);
        rsp.sum = sum;
        rsp.le  = (sum <= SUM_BITS'(req.lim));
    end

endmodule

FILE: rtl/layered_shelf_rect_packer_unit.sv
// Channel   Direction  Handshake         Payload
// s_        in         s_valid/s_ready   s_rect_width, s_rect_height
// m_        out        m_valid/m_ready   m_place_x, m_place_y, m_place_layer, m_status
// cfg_      in         cfg_we            cfg_addr, cfg_wdata
//
// After its transfer a request holds the sequencer: an empty one goes straight to the hand-over, one too
// wide or too tall stops at the width or height check, else k layers are rejected first and then the
// request fits on the open shelf, opens a new shelf, opens a new layer or finds the atlas full.
// Each rejected layer is a registered store read, a wait and four shared adder passes.
// s_ready is high only in idle; the hand-over cycle stalls while the output register is
// still full. Reset is synchronous (aresetn low) and needs no clearing pass.

module layered_shelf_rect_packer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lsrp_pkg::DIM_BITS-1:0]       s_rect_width,
    input  logic [lsrp_pkg::DIM_BITS-1:0]       s_rect_height,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lsrp_pkg::POS_BITS-1:0]       m_place_x,
    output logic [lsrp_pkg::POS_BITS-1:0]       m_place_y,
    output logic [lsrp_pkg::PLAYER_BITS-1:0]    m_place_layer,
    output logic [lsrp_pkg::STATUS_BITS-1:0]    m_status,
    input  logic                                cfg_we,
    input  logic [lsrp_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [lsrp_pkg::DIM_BITS-1:0]       cfg_wdata
);
    import lsrp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHKW = 4'd1;
    localparam logic [3:0] S_CHKH = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_WT   = 4'd4;
    localparam logic [3:0] S_TX   = 4'd5;
    localparam logic [3:0] S_TY   = 4'd6;
    localparam logic [3:0] S_TS   = 4'd7;
    localparam logic [3:0] S_TN   = 4'd8;
    localparam logic [3:0] S_NEWL = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    logic [3:0] state_reg, state_next;

    // Configuration
    logic [DIM_BITS-1:0]  atlas_w_reg, atlas_h_reg;
    logic [LCNT_BITS-1:0] max_layers_reg;

    // Atlas bookkeeping
    logic [LCNT_BITS-1:0] layers_used_reg, layers_used_next;
    logic                 l0_wr_reg, l0_wr_next;

    // Working registers
    logic [DIM_BITS-1:0]  w_reg, w_next, h_reg, h_next;
    logic [DIM_BITS-1:0]  pw_reg, pw_next, ph_reg, ph_next;
    logic [LCNT_BITS-1:0] idx_reg, idx_next;
    logic [DIM_BITS-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [DIM_BITS-1:0]  sh_reg, sh_next, nh_reg, nh_next;
    logic [DIM_BITS-1:0]  cxs_reg, cxs_next;
    logic                 fitx_reg, fitx_next;
    logic [OPA_BITS-1:0]  ny_reg, ny_next;

    // Pending result
    logic [POS_BITS-1:0]    res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [PLAYER_BITS-1:0] res_layer_reg, res_layer_next;
    logic [STATUS_BITS-1:0] res_status_reg, res_status_next;

    // Output register
    logic                   m_valid_reg, m_valid_next;
    logic [POS_BITS-1:0]    m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic [PLAYER_BITS-1:0] m_layer_reg, m_layer_next;
    logic [STATUS_BITS-1:0] m_status_reg, m_status_next;

    // Layer store ports
    logic                  ram_we;
    logic [LAYER_BITS-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;
    logic [DIM_BITS-1:0]   rd_cx, rd_cy, rd_sh;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    lsrp_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(MAX_LAYERS)
    ) u_layer_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    lsrp_alu u_alu (
        .req(alu_req),
        .rsp(alu_rsp)
    );

    assign ram_raddr = idx_reg[LAYER_BITS-1:0];

    // Layer zero reads as empty until it has first been written
    always_comb begin
        if (idx_reg == '0 && !l0_wr_reg) begin
            rd_cx = '0;
            rd_cy = '0;
            rd_sh = '0;
        end else begin
            rd_cx = ram_rdata[3*DIM_BITS-1:2*DIM_BITS];
            rd_cy = ram_rdata[2*DIM_BITS-1:DIM_BITS];
            rd_sh = ram_rdata[DIM_BITS-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        layers_used_next = layers_used_reg;
        l0_wr_next       = l0_wr_reg;
        w_next           = w_reg;
        h_next           = h_reg;
        pw_next          = pw_reg;
        ph_next          = ph_reg;
        idx_next         = idx_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        sh_next          = sh_reg;
        nh_next          = nh_reg;
        cxs_next         = cxs_reg;
        fitx_next        = fitx_reg;
        ny_next          = ny_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        res_layer_next   = res_layer_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg;
        m_x_next         = m_x_reg;
        m_y_next         = m_y_reg;
        m_layer_next     = m_layer_reg;
        m_status_next    = m_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg[LAYER_BITS-1:0];
        ram_wdata        = '0;
        alu_req.a        = '0;
        alu_req.b        = '0;
        alu_req.lim      = '0;

        // Drop the output once it has been taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    w_next          = s_rect_width;
                    h_next          = s_rect_height;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_layer_next  = '0;
                    res_status_next = ST_OK;
                    if (s_rect_width == '0 || s_rect_height == '0) begin
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_CHKW;
                    end
                end
            end
            S_CHKW: begin
                alu_req.a   = OPA_BITS'(w_reg);
                alu_req.b   = DIM_BITS'(1);
                alu_req.lim = atlas_w_reg;
                pw_next     = alu_rsp.sum[DIM_BITS-1:0];
                if (alu_rsp.le) begin
                    state_next = S_CHKH;
                end else begin
                    res_status_next = ST_TOO_LARGE;
                    state_next      = S_EMIT;
                end
            end
            S_CHKH: begin
                alu_req.a   = OPA_BITS'(h_reg);
                alu_req.b   = DIM_BITS'(1);
                alu_req.lim = atlas_h_reg;
                ph_next     = alu_rsp.sum[DIM_BITS-1:0];
                idx_next    = '0;
                if (alu_rsp.le) begin
                    state_next = S_RD;
                end else begin
                    res_status_next = ST_TOO_LARGE;
                    state_next      = S_EMIT;
                end
            end
            S_RD: begin
                if (idx_reg < layers_used_reg) begin
                    state_next = S_WT;
                end else begin
                    state_next = S_NEWL;
                end
            end
            S_WT: begin
                cx_next    = rd_cx;
                cy_next    = rd_cy;
                sh_next    = rd_sh;
                nh_next    = (rd_sh > ph_reg) ? rd_sh : ph_reg;
                state_next = S_TX;
            end
            S_TX: begin
                alu_req.a   = OPA_BITS'(cx_reg);
                alu_req.b   = pw_reg;
                alu_req.lim = atlas_w_reg;
                cxs_next    = alu_rsp.sum[DIM_BITS-1:0];
                fitx_next   = alu_rsp.le;
                state_next  = S_TY;
            end
            S_TY: begin
                alu_req.a   = OPA_BITS'(cy_reg);
                alu_req.b   = nh_reg;
                alu_req.lim = atlas_h_reg;
                if (fitx_reg && alu_rsp.le) begin
                    // Place on the open shelf
                    ram_we         = 1'b1;
                    ram_wdata      = {cxs_reg, cy_reg, nh_reg};
                    res_x_next     = cx_reg[POS_BITS-1:0];
                    res_y_next     = cy_reg[POS_BITS-1:0];
                    res_layer_next = idx_reg[PLAYER_BITS-1:0];
                    state_next     = S_EMIT;
                end else begin
                    state_next = S_TS;
                end
            end
            S_TS: begin
                alu_req.a   = OPA_BITS'(cy_reg);
                alu_req.b   = sh_reg;
                alu_req.lim = atlas_h_reg;
                ny_next     = alu_rsp.sum[OPA_BITS-1:0];
                state_next  = S_TN;
            end
            S_TN: begin
                alu_req.a   = ny_reg;
                alu_req.b   = ph_reg;
                alu_req.lim = atlas_h_reg;
                if (alu_rsp.le) begin
                    // Open a new shelf below the current one
                    ram_we         = 1'b1;
                    ram_wdata      = {pw_reg, ny_reg[DIM_BITS-1:0], ph_reg};
                    res_y_next     = ny_reg[POS_BITS-1:0];
                    res_layer_next = idx_reg[PLAYER_BITS-1:0];
                    state_next     = S_EMIT;
                end else begin
                    idx_next   = idx_reg + LCNT_BITS'(1);
                    state_next = S_RD;
                end
            end
            S_NEWL: begin
                if (layers_used_reg < max_layers_reg &&
                    layers_used_reg < LCNT_BITS'(MAX_LAYERS)) begin
                    ram_we           = 1'b1;
                    ram_waddr        = layers_used_reg[LAYER_BITS-1:0];
                    ram_wdata        = {pw_reg, {DIM_BITS{1'b0}}, ph_reg};
                    res_layer_next   = layers_used_reg[PLAYER_BITS-1:0];
                    layers_used_next = layers_used_reg + LCNT_BITS'(1);
                end else begin
                    res_status_next = ST_FULL;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // Hand the result over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_x_next      = res_x_reg;
                    m_y_next      = res_y_reg;
                    m_layer_next  = res_layer_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we && ram_waddr == '0) begin
            l0_wr_next = 1'b1;
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            layers_used_reg <= LCNT_BITS'(1);
            l0_wr_reg       <= 1'b0;
            atlas_w_reg     <= ATLAS_WIDTH_RST;
            atlas_h_reg     <= ATLAS_HEIGHT_RST;
            max_layers_reg  <= MAX_LAYERS_RST;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            layers_used_reg <= layers_used_next;
            l0_wr_reg       <= l0_wr_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_ATLAS_WIDTH:  atlas_w_reg    <= cfg_wdata;
                    REG_ATLAS_HEIGHT: atlas_h_reg    <= cfg_wdata;
                    REG_MAX_LAYERS:   max_layers_reg <= cfg_wdata[LCNT_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        w_reg          <= w_next;
        h_reg          <= h_next;
        pw_reg         <= pw_next;
        ph_reg         <= ph_next;
        idx_reg        <= idx_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        sh_reg         <= sh_next;
        nh_reg         <= nh_next;
        cxs_reg        <= cxs_next;
        fitx_reg       <= fitx_next;
        ny_reg         <= ny_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_layer_reg  <= res_layer_next;
        res_status_reg <= res_status_next;
        m_x_reg        <= m_x_next;
        m_y_reg        <= m_y_next;
        m_layer_reg    <= m_layer_next;
        m_status_reg   <= m_status_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_place_x     = m_x_reg;
    assign m_place_y     = m_y_reg;
    assign m_place_layer = m_layer_reg;
    assign m_status      = m_status_reg;

    // Layer count stays within the store
    a_layers_range: assert property (@(posedge aclk) disable iff (!aresetn)
        layers_used_reg != '0 && layers_used_reg <= LCNT_BITS'(MAX_LAYERS))
        else $error("layer count out of range");

    // Every store write is followed by a result hand-over
    a_write_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> state_reg == S_EMIT)
        else $error("store written without a result");

    // A layer is only fetched while it is in use
    a_fetch_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WT |-> idx_reg < layers_used_reg)
        else $error("fetched a layer not in use");

    // Error results carry zero coordinates
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |->
            m_place_x == '0 && m_place_y == '0 && m_place_layer == '0)
        else $error("error result with non-zero placement");

endmodule
